@@ rtl/core/rfcs_pkg.sv @@
// Shared types and constants of the rectangle fill cell store.
package rfcs_pkg;

  localparam int unsigned CoordW = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned DataW  = 4 * CoordW + ValueW;

  // Request kinds carried on the input tuser bit.
  localparam logic REQ_FILL = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register select bit taken from paddr[2].
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [SizeW-1:0]  SIZE_RESET = 7'd64;
  localparam logic [ValueW-1:0] MISS_VALUE = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RDWAIT,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/rfcs_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rfcs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                     wdata_i,
  input  logic                                 re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/rectangle_fill_cell_store.sv @@
// Top level of the rectangle fill cell store: control, range checks and row memory.
//
// The cells live in one RAM with one row of MAX_COLS cells per entry. A fill walks
// its rows one per cycle: each row is read, the columns of the rectangle are merged
// in, and the row is written back in the next cycle while the following row is read.
// A fill steps through ST_FILL once per row and then ST_DONE; a read that is in range
// passes through ST_RDWAIT and then ST_DONE, and a request that is out of range or
// covers no cells goes straight to ST_DONE. One item is in flight at a time; a result
// that waits on the output keeps the block in ST_DONE. A valid bit per row stands for
// the zero contents after reset, so no clearing pass is needed and items are accepted
// right after reset.
module rectangle_fill_cell_store
  import rfcs_pkg::*;
#(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Request stream.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tdata from bit 0: row_a[7:0], col_a[15:8], row_b[23:16], col_b[31:24],
  // fill_value[63:32].
  input  logic [DataW-1:0]  s_axis_tdata,
  // tuser: req_type.
  input  logic              s_axis_tuser,
  // Result stream.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // tdata: read_value[31:0].
  output logic [ValueW-1:0] m_axis_tdata,
  // tuser: in_range.
  output logic              m_axis_tuser
);

  localparam int unsigned RowAw  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned ColAw  = MAX_COLS > 1 ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RowBits = MAX_COLS * ValueW;
  localparam logic [8:0]  MaxRowsW = 9'(MAX_ROWS);
  localparam logic [8:0]  MaxColsW = 9'(MAX_COLS);

  // Configuration registers.
  logic [SizeW-1:0] rows_q, cols_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else if (cfg_we) begin
      if (paddr[2] == REG_ROWS) begin
        rows_q <= pwdata[SizeW-1:0];
      end else begin
        cols_q <= pwdata[SizeW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_COLS) ? 32'(cols_q) : 32'(rows_q);

  // Range checks on the incoming request.
  logic [8:0]        eff_rows, eff_cols;
  logic signed [CoordW-1:0] in_ra, in_ca, in_rb, in_cb;
  logic [ValueW-1:0] in_val;
  logic              ra_ok, ca_ok, rb_ok, cb_ok, fill_ok, fill_empty;

  assign eff_rows = (9'(rows_q) > MaxRowsW) ? MaxRowsW : 9'(rows_q);
  assign eff_cols = (9'(cols_q) > MaxColsW) ? MaxColsW : 9'(cols_q);

  assign in_ra  = s_axis_tdata[CoordW-1:0];
  assign in_ca  = s_axis_tdata[2*CoordW-1:CoordW];
  assign in_rb  = s_axis_tdata[3*CoordW-1:2*CoordW];
  assign in_cb  = s_axis_tdata[4*CoordW-1:3*CoordW];
  assign in_val = s_axis_tdata[DataW-1:4*CoordW];

  assign ra_ok = !in_ra[CoordW-1] && (9'(in_ra) < eff_rows);
  assign ca_ok = !in_ca[CoordW-1] && (9'(in_ca) < eff_cols);
  assign rb_ok = !in_rb[CoordW-1] && (9'(in_rb) < eff_rows);
  assign cb_ok = !in_cb[CoordW-1] && (9'(in_cb) < eff_cols);

  assign fill_ok    = ra_ok & ca_ok & rb_ok & cb_ok;
  assign fill_empty = (in_ra > in_rb) || (in_ca > in_cb);

  // Control.
  state_e state_q, state_d;
  logic   accept, out_free;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic [RowAw-1:0] row_q, row_end_q, wr_row_q;
  logic             wr_pend_q;
  logic [ColAw-1:0] rd_col_q;
  logic [MAX_COLS-1:0] mask_q;
  logic [ValueW-1:0]   val_q;
  logic [ValueW-1:0]   res_val_q;
  logic                res_ok_q;
  logic [MAX_ROWS-1:0] row_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == REQ_READ) begin
            state_d = (ra_ok && ca_ok) ? ST_RDWAIT : ST_DONE;
          end else begin
            state_d = (fill_ok && !fill_empty) ? ST_FILL : ST_DONE;
          end
        end
      end
      ST_FILL:   if (row_q == row_end_q) state_d = ST_DONE;
      ST_RDWAIT: state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // RAM port control.
  logic             ram_re, ram_we;
  logic [RowAw-1:0] ram_raddr;
  logic [RowBits-1:0] ram_rdata, ram_wdata;
  logic [MAX_COLS-1:0][ValueW-1:0] rd_lanes, wr_lanes;

  always_comb begin
    s_axis_tready = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = row_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ram_re        = s_axis_tvalid && (s_axis_tuser == REQ_READ) && ra_ok && ca_ok;
        ram_raddr     = in_ra[RowAw-1:0];
      end
      ST_FILL: begin
        ram_re    = 1'b1;
        ram_raddr = row_q;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  assign ram_we   = wr_pend_q;
  assign rd_lanes = ram_rdata;

  // A row never written since reset still reads as zero.
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      if (mask_q[j]) begin
        wr_lanes[j] = val_q;
      end else if (row_valid_q[wr_row_q]) begin
        wr_lanes[j] = rd_lanes[j];
      end else begin
        wr_lanes[j] = '0;
      end
    end
  end

  assign ram_wdata = wr_lanes;

  rfcs_ram #(
    .WIDTH (RowBits),
    .DEPTH (MAX_ROWS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_row_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_pend_q   <= 1'b0;
      row_valid_q <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_pend_q <= (state_q == ST_FILL);
      if (ram_we) begin
        row_valid_q[wr_row_q] <= 1'b1;
      end
      if (state_q == ST_DONE && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q     <= in_ra[RowAw-1:0];
      row_end_q <= in_rb[RowAw-1:0];
      rd_col_q  <= in_ca[ColAw-1:0];
      val_q     <= in_val;
      for (int j = 0; j < MAX_COLS; j++) begin
        mask_q[j] <= (9'(j) >= 9'(in_ca)) && (9'(j) <= 9'(in_cb));
      end
      if (s_axis_tuser == REQ_READ) begin
        res_val_q <= MISS_VALUE;
        res_ok_q  <= ra_ok & ca_ok;
      end else begin
        res_val_q <= '0;
        res_ok_q  <= fill_ok;
      end
    end else if (state_q == ST_FILL) begin
      row_q <= row_q + 1'b1;
    end else if (state_q == ST_RDWAIT) begin
      res_val_q <= row_valid_q[row_q] ? rd_lanes[rd_col_q] : '0;
    end
    wr_row_q <= row_q;
    if (state_q == ST_DONE && out_free) begin
      m_axis_tdata <= res_val_q;
      m_axis_tuser <= res_ok_q;
    end
  end

  // Checks.
  a_no_same_row_rw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (wr_row_q != ram_raddr))
    else $error("row read while the same row is written back");

  a_fill_in_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (row_q <= row_end_q))
    else $error("fill row counter ran past the end row");

  a_write_after_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_pend_q |-> $past(state_q == ST_FILL))
    else $error("row write-back without a fill read");

  a_read_then_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RDWAIT) |=> (state_q == ST_DONE))
    else $error("read result not handed on");

endmodule
